// ===== rtl/core/cts_pkg.sv =====
// Shared types, constants and the month length function for the calendar
// time-set editor. Used by rtl/core/calendar_time_set_editor.sv; no dependencies.
package cts_pkg;

	// Field widths.
	localparam int YEAR_W   = 7;
	localparam int MONTH_W  = 4;
	localparam int DAY_W    = 5;
	localparam int HOUR_W   = 5;
	localparam int MINUTE_W = 6;
	localparam int SECOND_W = 6;
	localparam int SEL_W    = 3;
	localparam int KEY_W    = 3;
	localparam int BLINK_W  = 10;

	// Field limits.
	localparam logic [YEAR_W-1:0]   YEAR_MAX   = 7'd99;
	localparam logic [MONTH_W-1:0]  MONTH_MAX  = 4'd12;
	localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
	localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
	localparam logic [SECOND_W-1:0] SECOND_MAX = 6'd59;
	localparam logic [DAY_W-1:0]    DAY_LONG   = 5'd31;
	localparam logic [DAY_W-1:0]    DAY_SHORT  = 5'd30;
	localparam logic [DAY_W-1:0]    DAY_FEB_LP = 5'd29;
	localparam logic [DAY_W-1:0]    DAY_FEB    = 5'd28;

	// Reset value of the blink half period register.
	localparam logic [BLINK_W-1:0]  BLINK_RESET = 10'd500;

	// Opcodes of an input transaction.
	typedef enum logic {
		OP_TICK = 1'b0,
		OP_KEY  = 1'b1
	} op_t;

	// Key codes; other codes do nothing.
	typedef enum logic [KEY_W-1:0] {
		KEY_NONE = 3'd0,
		KEY_MODE = 3'd1,
		KEY_NEXT = 3'd2,
		KEY_INC  = 3'd3,
		KEY_DEC  = 3'd4
	} key_t;

	// Selected field codes.
	typedef enum logic [SEL_W-1:0] {
		SEL_YEAR   = 3'd0,
		SEL_MONTH  = 3'd1,
		SEL_DAY    = 3'd2,
		SEL_HOUR   = 3'd3,
		SEL_MINUTE = 3'd4,
		SEL_SECOND = 3'd5
	} sel_t;

	// Length of a month; zero means an invalid month, for which no day check applies.
	function automatic logic [DAY_W-1:0] month_limit(input logic [MONTH_W-1:0] m,
			input logic [YEAR_W-1:0] y);
		logic [DAY_W-1:0] lim;
		begin
			case (m) inside
				4'd2: lim = (y[1:0] == 2'b00) ? DAY_FEB_LP : DAY_FEB;
				4'd4, 4'd6, 4'd9, 4'd11: lim = DAY_SHORT;
				[4'd1:4'd12]: lim = DAY_LONG;
				default: lim = '0;
			endcase
			return lim;
		end
	endfunction

endpackage

// ===== rtl/core/calendar_time_set_editor.sv =====
// Calendar time-set editor: holds and edits year, month, day, hour, minute and second.
// Depends on rtl/core/cts_pkg.sv.
//
// The block takes one transaction per clock cycle unless the output stalls and
// gives one result per transaction. A result can be taken whenever the output
// is not stalled. An input register holds the accepted item. The update logic
// sits between it and the held time registers, which also serve as the result
// register. While a result is stalled, one further item is still accepted into
// the input register. Throughput is set by that single input register and the
// single result register.
module calendar_time_set_editor (
	input  logic                          clk,
	input  logic                          arst_n,
	// Configuration port.
	input  logic                          blink_half_period_we,
	input  logic [cts_pkg::BLINK_W-1:0]   blink_half_period,
	// Input channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          opcode,
	input  logic [cts_pkg::KEY_W-1:0]     key,
	input  logic [cts_pkg::YEAR_W-1:0]    rtc_year,
	input  logic [cts_pkg::MONTH_W-1:0]   rtc_month,
	input  logic [cts_pkg::DAY_W-1:0]     rtc_day,
	input  logic [cts_pkg::HOUR_W-1:0]    rtc_hour,
	input  logic [cts_pkg::MINUTE_W-1:0]  rtc_minute,
	input  logic [cts_pkg::SECOND_W-1:0]  rtc_second,
	// Output channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [cts_pkg::YEAR_W-1:0]    year,
	output logic [cts_pkg::MONTH_W-1:0]   month,
	output logic [cts_pkg::DAY_W-1:0]     day,
	output logic [cts_pkg::HOUR_W-1:0]    hour,
	output logic [cts_pkg::MINUTE_W-1:0]  minute,
	output logic [cts_pkg::SECOND_W-1:0]  second,
	output logic                          set_mode,
	output logic [cts_pkg::SEL_W-1:0]     selected_field,
	output logic                          blink_blank,
	output logic                          commit
);
	import cts_pkg::*;

	// Configuration register.
	logic [BLINK_W-1:0] bhp_q;

	// Input stage.
	logic                valid_s1;
	logic                opcode_s1;
	logic [KEY_W-1:0]    key_s1;
	logic [YEAR_W-1:0]   rtc_year_s1;
	logic [MONTH_W-1:0]  rtc_month_s1;
	logic [DAY_W-1:0]    rtc_day_s1;
	logic [HOUR_W-1:0]   rtc_hour_s1;
	logic [MINUTE_W-1:0] rtc_minute_s1;
	logic [SECOND_W-1:0] rtc_second_s1;

	// Held state, which is also the result.
	logic                out_valid_q;
	logic [YEAR_W-1:0]   year_q;
	logic [MONTH_W-1:0]  month_q;
	logic [DAY_W-1:0]    day_q;
	logic [HOUR_W-1:0]   hour_q;
	logic [MINUTE_W-1:0] minute_q;
	logic [SECOND_W-1:0] second_q;
	logic                mode_q;
	logic [SEL_W-1:0]    sel_q;
	logic                blink_q;
	logic [BLINK_W-1:0]  tick_q;
	logic                commit_q;

	// Next-state values.
	logic                advance;
	logic                accept_in;
	logic [BLINK_W:0]    tick_inc;
	logic [BLINK_W-1:0]  tick_n;
	logic                blink_n;
	logic                mode_n;
	logic [SEL_W-1:0]    sel_n;
	logic                commit_n;
	logic                load;
	logic                is_key;
	logic                do_inc;
	logic                do_dec;

	// Increment path.
	logic [YEAR_W:0]     yi_raw;
	logic [MONTH_W:0]    mi_raw;
	logic [DAY_W:0]      di_raw;
	logic [HOUR_W:0]     hi_raw;
	logic [MINUTE_W:0]   ni_raw;
	logic [SECOND_W:0]   si_raw;
	logic [YEAR_W-1:0]   y_inc;
	logic [MONTH_W-1:0]  m_inc;
	logic [DAY_W-1:0]    d_inc;
	logic [HOUR_W-1:0]   h_inc;
	logic [MINUTE_W-1:0] n_inc;
	logic [SECOND_W-1:0] s_inc;
	logic [DAY_W-1:0]    lim_inc;

	// Decrement path.
	logic [YEAR_W-1:0]   y_dec;
	logic [MONTH_W-1:0]  m_dec;
	logic [DAY_W-1:0]    d_step;
	logic [DAY_W-1:0]    d_dec;
	logic [HOUR_W-1:0]   h_dec;
	logic [MINUTE_W-1:0] n_dec;
	logic [SECOND_W-1:0] s_dec;
	logic [DAY_W-1:0]    lim_dec;

	// Field select decode.
	logic sel_y, sel_m, sel_d, sel_h, sel_n_min, sel_s;

	// Handshake: the input register moves on whenever the result register is free.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept_in = in_valid && !in_stall;

	// Configuration write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bhp_q <= BLINK_RESET;
		end else if (blink_half_period_we) begin
			bhp_q <= blink_half_period;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_in) begin
			opcode_s1     <= opcode;
			key_s1        <= key;
			rtc_year_s1   <= rtc_year;
			rtc_month_s1  <= rtc_month;
			rtc_day_s1    <= rtc_day;
			rtc_hour_s1   <= rtc_hour;
			rtc_minute_s1 <= rtc_minute;
			rtc_second_s1 <= rtc_second;
		end
	end

	assign sel_y     = (sel_q == SEL_YEAR);
	assign sel_m     = (sel_q == SEL_MONTH);
	assign sel_d     = (sel_q == SEL_DAY);
	assign sel_h     = (sel_q == SEL_HOUR);
	assign sel_n_min = (sel_q == SEL_MINUTE);
	assign sel_s     = !(sel_y || sel_m || sel_d || sel_h || sel_n_min);

	// Increment: step the selected field, then wrap every field that is above range.
	always_comb begin
		yi_raw = {1'b0, year_q}   + {{YEAR_W{1'b0}}, sel_y};
		mi_raw = {1'b0, month_q}  + {{MONTH_W{1'b0}}, sel_m};
		di_raw = {1'b0, day_q}    + {{DAY_W{1'b0}}, sel_d};
		hi_raw = {1'b0, hour_q}   + {{HOUR_W{1'b0}}, sel_h};
		ni_raw = {1'b0, minute_q} + {{MINUTE_W{1'b0}}, sel_n_min};
		si_raw = {1'b0, second_q} + {{SECOND_W{1'b0}}, sel_s};
		y_inc  = (yi_raw > {1'b0, YEAR_MAX})  ? '0 : yi_raw[YEAR_W-1:0];
		m_inc  = (mi_raw > {1'b0, MONTH_MAX}) ? MONTH_W'(1) : mi_raw[MONTH_W-1:0];
		lim_inc = month_limit(m_inc, y_inc);
		d_inc  = ((lim_inc != '0) && (di_raw > {1'b0, lim_inc})) ? DAY_W'(1)
				: di_raw[DAY_W-1:0];
		h_inc  = (hi_raw > {1'b0, HOUR_MAX})   ? '0 : hi_raw[HOUR_W-1:0];
		n_inc  = (ni_raw > {1'b0, MINUTE_MAX}) ? '0 : ni_raw[MINUTE_W-1:0];
		s_inc  = (si_raw > {1'b0, SECOND_MAX}) ? '0 : si_raw[SECOND_W-1:0];
	end

	// Decrement: step the selected field down, wrap below range, clamp short months.
	always_comb begin
		y_dec = (sel_y && (year_q == '0)) ? YEAR_MAX
				: year_q - {{(YEAR_W-1){1'b0}}, sel_y};
		m_dec = (month_q <= {{(MONTH_W-1){1'b0}}, sel_m}) ? MONTH_MAX
				: month_q - {{(MONTH_W-1){1'b0}}, sel_m};
		lim_dec = month_limit(m_dec, y_dec);
		d_step  = day_q - {{(DAY_W-1){1'b0}}, sel_d};
		if (lim_dec == '0) begin
			d_dec = d_step;
		end else if (day_q <= {{(DAY_W-1){1'b0}}, sel_d}) begin
			d_dec = lim_dec;
		end else if ((lim_dec < DAY_LONG) && (d_step > lim_dec)) begin
			d_dec = lim_dec;
		end else begin
			d_dec = d_step;
		end
		h_dec = (sel_h && (hour_q == '0)) ? HOUR_MAX
				: hour_q - {{(HOUR_W-1){1'b0}}, sel_h};
		n_dec = (sel_n_min && (minute_q == '0)) ? MINUTE_MAX
				: minute_q - {{(MINUTE_W-1){1'b0}}, sel_n_min};
		s_dec = (sel_s && (second_q == '0)) ? SECOND_MAX
				: second_q - {{(SECOND_W-1){1'b0}}, sel_s};
	end

	// Control: blink timer, mode toggle, field selection and commit strobe.
	always_comb begin
		is_key   = (opcode_s1 == OP_KEY);
		tick_inc = {1'b0, tick_q} + {{BLINK_W{1'b0}}, 1'b1};
		tick_n   = tick_q;
		blink_n  = blink_q;
		mode_n   = mode_q;
		sel_n    = sel_q;
		commit_n = 1'b0;
		load     = 1'b1;
		if (!is_key) begin
			if (tick_inc >= {1'b0, bhp_q}) begin
				tick_n  = '0;
				blink_n = !blink_q;
			end else begin
				tick_n = tick_inc[BLINK_W-1:0];
			end
		end else if (key_s1 == KEY_MODE) begin
			if (!mode_q) begin
				mode_n = 1'b1;
				sel_n  = SEL_YEAR;
			end else begin
				mode_n   = 1'b0;
				commit_n = 1'b1;
				load     = 1'b0;
			end
		end
		if (is_key && mode_n && (key_s1 == KEY_NEXT)) begin
			sel_n = (sel_q == SEL_SECOND) ? SEL_YEAR : sel_q + SEL_W'(1);
		end
		do_inc = is_key && mode_n && (key_s1 == KEY_INC);
		do_dec = is_key && mode_n && (key_s1 == KEY_DEC);
	end

	// Held state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			year_q      <= '0;
			month_q     <= MONTH_W'(1);
			day_q       <= DAY_W'(1);
			hour_q      <= '0;
			minute_q    <= '0;
			second_q    <= '0;
			mode_q      <= 1'b0;
			sel_q       <= SEL_YEAR;
			blink_q     <= 1'b0;
			tick_q      <= '0;
			commit_q    <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
			mode_q      <= mode_n;
			sel_q       <= sel_n;
			blink_q     <= blink_n;
			tick_q      <= tick_n;
			commit_q    <= commit_n;
			if (!mode_n && load) begin
				year_q   <= rtc_year_s1;
				month_q  <= rtc_month_s1;
				day_q    <= rtc_day_s1;
				hour_q   <= rtc_hour_s1;
				minute_q <= rtc_minute_s1;
				second_q <= rtc_second_s1;
			end else if (do_inc) begin
				year_q   <= y_inc;
				month_q  <= m_inc;
				day_q    <= d_inc;
				hour_q   <= h_inc;
				minute_q <= n_inc;
				second_q <= s_inc;
			end else if (do_dec) begin
				year_q   <= y_dec;
				month_q  <= m_dec;
				day_q    <= d_dec;
				hour_q   <= h_dec;
				minute_q <= n_dec;
				second_q <= s_dec;
			end
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid      = out_valid_q;
	assign year           = year_q;
	assign month          = month_q;
	assign day            = day_q;
	assign hour           = hour_q;
	assign minute         = minute_q;
	assign second         = second_q;
	assign set_mode       = mode_q;
	assign selected_field = sel_q;
	assign blink_blank    = mode_q && blink_q;
	assign commit         = commit_q;

	// A commit result always leaves the block in show mode.
	a_commit_show: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && commit) |-> !set_mode)
		else $error("commit raised while still in set mode");

	// The selection never leaves the six fields.
	a_sel_range: assert property (@(posedge clk) disable iff (!arst_n)
		selected_field <= SEL_SECOND)
		else $error("selected field out of range");

	// The input side is never stalled while the input register is empty.
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("input stalled with an empty input register");

	// A stalled result is never dropped.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("stalled result was dropped");

	// After a tick the blink counter stays below a nonzero half period and is zero otherwise.
	a_tick_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !opcode_s1 && !blink_half_period_we)
		|=> ((tick_q < bhp_q) || (tick_q == '0)))
		else $error("blink counter reached its half period");

endmodule

// ===== tb/editor_checker.sv =====
// Checker for the calendar time-set editor: watches both channels and the period register port,
// predicts each result from the accepted input transactions and compares it with the output.
// Depends on rtl/core/cts_pkg.sv.
`timescale 1ns / 100ps

module editor_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          period_we,
	input  logic [cts_pkg::BLINK_W-1:0]   period_data,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          opcode,
	input  logic [cts_pkg::KEY_W-1:0]     key,
	input  logic [cts_pkg::YEAR_W-1:0]    rtc_year,
	input  logic [cts_pkg::MONTH_W-1:0]   rtc_month,
	input  logic [cts_pkg::DAY_W-1:0]     rtc_day,
	input  logic [cts_pkg::HOUR_W-1:0]    rtc_hour,
	input  logic [cts_pkg::MINUTE_W-1:0]  rtc_minute,
	input  logic [cts_pkg::SECOND_W-1:0]  rtc_second,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic [cts_pkg::YEAR_W-1:0]    year,
	input  logic [cts_pkg::MONTH_W-1:0]   month,
	input  logic [cts_pkg::DAY_W-1:0]     day,
	input  logic [cts_pkg::HOUR_W-1:0]    hour,
	input  logic [cts_pkg::MINUTE_W-1:0]  minute,
	input  logic [cts_pkg::SECOND_W-1:0]  second,
	input  logic                          set_mode,
	input  logic [cts_pkg::SEL_W-1:0]     selected_field,
	input  logic                          blink_blank,
	input  logic                          commit,
	output int                            outstanding,
	output int                            mismatches
);
	import cts_pkg::*;

	localparam int MAX_REPORTS = 10;
	localparam int YEAR_TOP    = int'(YEAR_MAX);
	localparam int MONTH_TOP   = int'(MONTH_MAX);
	localparam int HOUR_TOP    = int'(HOUR_MAX);
	localparam int MINUTE_TOP  = int'(MINUTE_MAX);
	localparam int SECOND_TOP  = int'(SECOND_MAX);
	localparam int DAYS_LONG   = int'(DAY_LONG);

	// One displayed state of the editor, as it appears on the output channel.
	typedef struct packed {
		logic [YEAR_W-1:0]   year;
		logic [MONTH_W-1:0]  month;
		logic [DAY_W-1:0]    day;
		logic [HOUR_W-1:0]   hour;
		logic [MINUTE_W-1:0] minute;
		logic [SECOND_W-1:0] second;
		logic                set_mode;
		logic [SEL_W-1:0]    sel;
		logic                blank;
		logic                commit;
	} view_t;

	view_t display_q[$];

	// Predicted editor state; time fields are signed so that steps below zero are seen.
	int cal_year, cal_month, cal_day, cal_hour, cal_minute, cal_second;
	logic               editing;
	logic [SEL_W-1:0]   field_sel;
	logic               blink;
	logic [BLINK_W-1:0] tick_cnt;
	logic [BLINK_W-1:0] half_period;
	int                 fail_total;

	// Days in a month; zero for an invalid month, which gets no day check.
	function automatic int days_in_month(input int m, input int y);
		if (m == 2)
			return ((y & 3) == 0) ? int'(DAY_FEB_LP) : int'(DAY_FEB);
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return int'(DAY_SHORT);
		if (m >= 1 && m <= MONTH_TOP)
			return DAYS_LONG;
		return 0;
	endfunction

	function automatic string show(input view_t v);
		return $sformatf("%0d-%0d-%0d %0d:%0d:%0d set=%0b sel=%0d blank=%0b commit=%0b",
			v.year, v.month, v.day, v.hour, v.minute, v.second,
			v.set_mode, v.sel, v.blank, v.commit);
	endfunction

	// One increment or decrement of the selected field, then the range checks on all fields.
	task automatic step_field(input bit up);
		int delta;
		int lim;
		delta = up ? 1 : -1;
		case (field_sel)
			SEL_YEAR:   cal_year   += delta;
			SEL_MONTH:  cal_month  += delta;
			SEL_DAY:    cal_day    += delta;
			SEL_HOUR:   cal_hour   += delta;
			SEL_MINUTE: cal_minute += delta;
			default:    cal_second += delta;
		endcase
		if (up) begin
			if (cal_year > YEAR_TOP) cal_year = 0;
			if (cal_month > MONTH_TOP) cal_month = 1;
			lim = days_in_month(cal_month, cal_year);
			if (lim != 0 && cal_day > lim) cal_day = 1;
			if (cal_hour > HOUR_TOP) cal_hour = 0;
			if (cal_minute > MINUTE_TOP) cal_minute = 0;
			if (cal_second > SECOND_TOP) cal_second = 0;
		end else begin
			if (cal_year < 0) cal_year = YEAR_TOP;
			if (cal_month < 1) cal_month = MONTH_TOP;
			lim = days_in_month(cal_month, cal_year);
			if (lim != 0) begin
				if (cal_day < 1) cal_day = lim;
				// Short months clamp a day that no longer fits.
				if (lim < DAYS_LONG && cal_day > lim) cal_day = lim;
			end
			if (cal_hour < 0) cal_hour = HOUR_TOP;
			if (cal_minute < 0) cal_minute = MINUTE_TOP;
			if (cal_second < 0) cal_second = SECOND_TOP;
		end
		cal_year   = cal_year   & ((1 << YEAR_W) - 1);
		cal_month  = cal_month  & ((1 << MONTH_W) - 1);
		cal_day    = cal_day    & ((1 << DAY_W) - 1);
		cal_hour   = cal_hour   & ((1 << HOUR_W) - 1);
		cal_minute = cal_minute & ((1 << MINUTE_W) - 1);
		cal_second = cal_second & ((1 << SECOND_W) - 1);
	endtask

	// Advance the predicted state by one accepted transaction and queue the expected view.
	task automatic predict_view();
		view_t v;
		bit    strobe;
		bit    load;
		strobe = 1'b0;
		load   = 1'b1;
		if (opcode == OP_TICK) begin
			if (tick_cnt + 1 >= half_period) begin
				tick_cnt = '0;
				blink    = ~blink;
			end else begin
				tick_cnt = tick_cnt + 1'b1;
			end
		end else begin
			if (key == KEY_MODE) begin
				if (!editing) begin
					editing   = 1'b1;
					field_sel = SEL_YEAR;
				end else begin
					// Leaving set mode commits the edited time instead of loading.
					editing = 1'b0;
					strobe  = 1'b1;
					load    = 1'b0;
				end
			end
			if (editing) begin
				case (key)
					KEY_NEXT: field_sel = (field_sel == SEL_SECOND) ? SEL_YEAR : field_sel + 1'b1;
					KEY_INC:  step_field(1'b1);
					KEY_DEC:  step_field(1'b0);
					default: ;
				endcase
			end
		end
		if (!editing && load) begin
			cal_year   = int'(rtc_year);
			cal_month  = int'(rtc_month);
			cal_day    = int'(rtc_day);
			cal_hour   = int'(rtc_hour);
			cal_minute = int'(rtc_minute);
			cal_second = int'(rtc_second);
		end
		v.year     = cal_year[YEAR_W-1:0];
		v.month    = cal_month[MONTH_W-1:0];
		v.day      = cal_day[DAY_W-1:0];
		v.hour     = cal_hour[HOUR_W-1:0];
		v.minute   = cal_minute[MINUTE_W-1:0];
		v.second   = cal_second[SECOND_W-1:0];
		v.set_mode = editing;
		v.sel      = field_sel;
		v.blank    = editing & blink;
		v.commit   = strobe;
		display_q.push_back(v);
	endtask

	// Channel monitor: results are matched first, then the new transaction is predicted.
	always @(posedge clk or negedge arst_n) begin
		view_t got;
		view_t want;
		string diffs;
		if (!arst_n) begin
			display_q.delete();
			cal_year    = 0;
			cal_month   = 1;
			cal_day     = 1;
			cal_hour    = 0;
			cal_minute  = 0;
			cal_second  = 0;
			editing     = 1'b0;
			field_sel   = SEL_YEAR;
			blink       = 1'b0;
			tick_cnt    = '0;
			half_period = BLINK_RESET;
			fail_total  = 0;
			outstanding <= 0;
			mismatches  <= 0;
		end else begin
			if (period_we === 1'b1)
				half_period = period_data;

			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				got = {year, month, day, hour, minute, second,
					set_mode, selected_field, blink_blank, commit};
				if (display_q.size() == 0) begin
					fail_total++;
					if (fail_total <= MAX_REPORTS)
						$display("%0t: result with no transaction pending: %s", $realtime, show(got));
				end else begin
					want  = display_q.pop_front();
					diffs = "";
					if (got.year !== want.year) diffs = {diffs, " year"};
					if (got.month !== want.month) diffs = {diffs, " month"};
					if (got.day !== want.day) diffs = {diffs, " day"};
					if (got.hour !== want.hour) diffs = {diffs, " hour"};
					if (got.minute !== want.minute) diffs = {diffs, " minute"};
					if (got.second !== want.second) diffs = {diffs, " second"};
					if (got.set_mode !== want.set_mode) diffs = {diffs, " set_mode"};
					if (got.sel !== want.sel) diffs = {diffs, " selected_field"};
					if (got.blank !== want.blank) diffs = {diffs, " blink_blank"};
					if (got.commit !== want.commit) diffs = {diffs, " commit"};
					if (diffs != "") begin
						fail_total++;
						if (fail_total <= MAX_REPORTS)
							$display("%0t: mismatch in%s\n  expected %s\n  actual   %s",
								$realtime, diffs, show(want), show(got));
					end
				end
			end

			if (in_valid === 1'b1 && in_stall === 1'b0)
				predict_view();

			outstanding <= display_q.size();
			mismatches  <= fail_total;
		end
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the calendar time-set editor testbench: clock, reset, stimulus, output stalls and verdict.
// Depends on rtl/core/cts_pkg.sv, rtl/core/calendar_time_set_editor.sv and tb/editor_checker.sv.
`timescale 1ns / 100ps

module testbench;
	import cts_pkg::*;

	localparam int PHASE_ITEMS  = 250;
	localparam int LONG_HOLD    = 64;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [KEY_W-1:0]   KEY_SPARE_FIRST = 3'd5;
	localparam logic [KEY_W-1:0]   KEY_SPARE_LAST  = 3'd7;
	localparam logic [BLINK_W-1:0] PERIOD_MAX      = '1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                blink_half_period_we = 1'b0;
	logic [BLINK_W-1:0]  blink_half_period = BLINK_RESET;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic                opcode = OP_TICK;
	logic [KEY_W-1:0]    key = KEY_NONE;
	logic [YEAR_W-1:0]   rtc_year = '0;
	logic [MONTH_W-1:0]  rtc_month = 4'd1;
	logic [DAY_W-1:0]    rtc_day = 5'd1;
	logic [HOUR_W-1:0]   rtc_hour = '0;
	logic [MINUTE_W-1:0] rtc_minute = '0;
	logic [SECOND_W-1:0] rtc_second = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [YEAR_W-1:0]   year;
	logic [MONTH_W-1:0]  month;
	logic [DAY_W-1:0]    day;
	logic [HOUR_W-1:0]   hour;
	logic [MINUTE_W-1:0] minute;
	logic [SECOND_W-1:0] second;
	logic                set_mode;
	logic [SEL_W-1:0]    selected_field;
	logic                blink_blank;
	logic                commit;

	int outstanding;
	int mismatches;
	int sent_count = 0;
	bit quiet = 1'b0;
	bit hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	calendar_time_set_editor u_top (
		.clk                  (clk),
		.arst_n               (arst_n),
		.blink_half_period_we (blink_half_period_we),
		.blink_half_period    (blink_half_period),
		.in_valid             (in_valid),
		.in_stall             (in_stall),
		.opcode               (opcode),
		.key                  (key),
		.rtc_year             (rtc_year),
		.rtc_month            (rtc_month),
		.rtc_day              (rtc_day),
		.rtc_hour             (rtc_hour),
		.rtc_minute           (rtc_minute),
		.rtc_second           (rtc_second),
		.out_valid            (out_valid),
		.out_stall            (out_stall),
		.year                 (year),
		.month                (month),
		.day                  (day),
		.hour                 (hour),
		.minute               (minute),
		.second               (second),
		.set_mode             (set_mode),
		.selected_field       (selected_field),
		.blink_blank          (blink_blank),
		.commit               (commit)
	);

	editor_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.period_we      (blink_half_period_we),
		.period_data    (blink_half_period),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.key            (key),
		.rtc_year       (rtc_year),
		.rtc_month      (rtc_month),
		.rtc_day        (rtc_day),
		.rtc_hour       (rtc_hour),
		.rtc_minute     (rtc_minute),
		.rtc_second     (rtc_second),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.year           (year),
		.month          (month),
		.day            (day),
		.hour           (hour),
		.minute         (minute),
		.second         (second),
		.set_mode       (set_mode),
		.selected_field (selected_field),
		.blink_blank    (blink_blank),
		.commit         (commit),
		.outstanding    (outstanding),
		.mismatches     (mismatches)
	);

	// Offer one transaction, hold it until accepted, then maybe leave a short gap.
	task automatic send_item(input op_t op, input logic [KEY_W-1:0] k,
			input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] mo,
			input logic [DAY_W-1:0] d, input logic [HOUR_W-1:0] h,
			input logic [MINUTE_W-1:0] mi, input logic [SECOND_W-1:0] s);
		opcode     <= op;
		key        <= k;
		rtc_year   <= y;
		rtc_month  <= mo;
		rtc_day    <= d;
		rtc_hour   <= h;
		rtc_minute <= mi;
		rtc_second <= s;
		in_valid   <= 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		sent_count++;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Mostly plausible clock-chip readings, sometimes any value the port width allows.
	task automatic send_random(input op_t op, input logic [KEY_W-1:0] k);
		if ($urandom_range(0, 9) == 0)
			send_item(op, k, YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
				HOUR_W'($urandom), MINUTE_W'($urandom), SECOND_W'($urandom));
		else
			send_item(op, k, YEAR_W'($urandom_range(0, YEAR_MAX)),
				MONTH_W'($urandom_range(1, MONTH_MAX)),
				DAY_W'($urandom_range(1, DAY_LONG)), HOUR_W'($urandom_range(0, HOUR_MAX)),
				MINUTE_W'($urandom_range(0, MINUTE_MAX)),
				SECOND_W'($urandom_range(0, SECOND_MAX)));
	endtask

	// Any opcode, any key code and any field bits.
	task automatic send_noise();
		logic             op_bit;
		logic [KEY_W-1:0] k;
		op_bit = 1'($urandom);
		k      = KEY_W'($urandom);
		send_item(op_t'(op_bit), k, YEAR_W'($urandom), MONTH_W'($urandom), DAY_W'($urandom),
			HOUR_W'($urandom), MINUTE_W'($urandom), SECOND_W'($urandom));
	endtask

	// A well-formed editing session: show, enter set mode, edit, leave with a commit.
	task automatic edit_session();
		int               pick;
		logic             op_bit;
		logic [KEY_W-1:0] k;
		repeat ($urandom_range(1, 3)) begin
			op_bit = 1'($urandom);
			send_random(op_t'(op_bit), KEY_NONE);
		end
		send_random(OP_KEY, KEY_MODE);
		repeat ($urandom_range(2, 16)) begin
			pick = $urandom_range(0, 19);
			k    = KEY_W'($urandom);
			if (pick < 4)
				send_random(OP_KEY, KEY_NEXT);
			else if (pick < 10)
				send_random(OP_KEY, KEY_INC);
			else if (pick < 16)
				send_random(OP_KEY, KEY_DEC);
			else if (pick < 18)
				send_random(OP_TICK, k);
			else if (pick < 19)
				send_random(OP_KEY, KEY_W'($urandom_range(KEY_SPARE_FIRST, KEY_SPARE_LAST)));
			else
				send_random(OP_KEY, KEY_NONE);
		end
		send_random(OP_KEY, KEY_MODE);
	endtask

	task automatic run_phase(input int n_items);
		int stop_at;
		stop_at = sent_count + n_items;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 99) < 85)
				edit_session();
			else
				send_noise();
		end
	endtask

	// Stop offering and wait until every expected result has arrived.
	task automatic drain();
		in_valid <= 1'b0;
		// Wait for a clock edge first, so that the count includes the last accepted transaction.
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_period(input logic [BLINK_W-1:0] p);
		blink_half_period_we <= 1'b1;
		blink_half_period    <= p;
		@(posedge clk);
		blink_half_period_we <= 1'b0;
	endtask

	// Output side: random stall bursts, one long hold on request, none in the quiet part.
	initial begin
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
				out_stall <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset state: enter set mode on the held reset time, tick, leave with a commit.
		send_item(OP_KEY, KEY_MODE, YEAR_MAX, MONTH_MAX, DAY_LONG, HOUR_MAX, MINUTE_MAX, SECOND_MAX);
		send_item(OP_TICK, KEY_NONE, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_MODE, '0, '0, '0, '0, '0, '0);
		drain();
		set_period(BLINK_W'(2));

		// Upper limits: year, month and day wrap and come back; hour and minute wrap on increment.
		send_item(OP_KEY, KEY_NONE, YEAR_MAX, MONTH_MAX, DAY_LONG, HOUR_MAX, MINUTE_MAX, SECOND_MAX);
		send_item(OP_KEY, KEY_MODE, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_INC, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_DEC, '1, '1, '1, '1, '1, '1);
		send_item(OP_KEY, KEY_NEXT, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_INC, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_DEC, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_NEXT, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_INC, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_DEC, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_NEXT, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_INC, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_NEXT, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_INC, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_NEXT, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_DEC, '0, '0, '0, '0, '0, '0);
		// Selection wraps from second back to year; ticks blink the selected field.
		send_item(OP_KEY, KEY_NEXT, '0, '0, '0, '0, '0, '0);
		send_item(OP_TICK, KEY_INC, '0, '0, '0, '0, '0, '0);
		send_item(OP_TICK, KEY_NONE, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_SPARE_LAST, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_MODE, '0, '0, '0, '0, '0, '0);

		// February in a non-leap year: the day is clamped when the month is decremented from March.
		send_item(OP_KEY, KEY_NONE, 7'd3, 4'd3, DAY_LONG, '0, '0, '0);
		send_item(OP_KEY, KEY_MODE, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_NEXT, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_DEC, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_MODE, '0, '0, '0, '0, '0, '0);

		// Out-of-range clock-chip values, then a year increment that rechecks every field.
		send_item(OP_TICK, KEY_NONE, '1, '1, '0, '1, '1, '1);
		send_item(OP_KEY, KEY_MODE, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_INC, '0, '0, '0, '0, '0, '0);
		send_item(OP_KEY, KEY_MODE, '0, '0, '0, '0, '0, '0);
		drain();

		// Random phases over several blink periods, the extremes among them.
		set_period(BLINK_W'(1));
		run_phase(PHASE_ITEMS);
		drain();
		set_period(PERIOD_MAX);
		hold_req = 1'b1;
		run_phase(PHASE_ITEMS);
		drain();
		set_period('0);
		run_phase(PHASE_ITEMS);
		drain();
		set_period(BLINK_W'($urandom_range(2, 9)));
		run_phase(PHASE_ITEMS);
		drain();
		set_period(BLINK_W'($urandom_range(1, PERIOD_MAX)));
		run_phase(PHASE_ITEMS);
		drain();
		quiet = 1'b1;
		set_period(BLINK_W'(3));
		run_phase(PHASE_ITEMS);
		drain();

		if (mismatches == 0 && outstanding == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
